// File: sv/lew_pkg.sv
// shared constants and types for the line editor with history
package lew_pkg;

  localparam int MAX_LINE   = 128;
  localparam int HIST_DEPTH = 8;

  localparam int LEN_W = $clog2(MAX_LINE);
  localparam int HS_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int HU_W  = $clog2(HIST_DEPTH + 1);
  localparam int HA_W  = (HIST_DEPTH * MAX_LINE > 1) ? $clog2(HIST_DEPTH * MAX_LINE) : 1;
  localparam int CW    = 10;

  localparam int NUM_CODES = 8;

  localparam logic [7:0] KEY_NL   = 8'd10;
  localparam logic [7:0] KEY_BS   = 8'd8;
  localparam logic [7:0] KEY_TAB  = 8'd9;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    REG_UP       = 3'd0,
    REG_DOWN     = 3'd1,
    REG_LEFT     = 3'd2,
    REG_RIGHT    = 3'd3,
    REG_HOME     = 3'd4,
    REG_END      = 3'd5,
    REG_DELETE   = 3'd6,
    REG_BACK_TAB = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_INS  = 3'd1,
    OP_DEL  = 3'd2,
    OP_PUSH = 3'd3,
    OP_LOAD = 3'd4,
    OP_CMP  = 3'd5,
    OP_READ = 3'd6
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

// File: sv/line_editor_with_history.sv
// line editor with cursor and newest-first history, top level
//
// usage:
//   in_ channel: in_tuser carries the command (key, read byte, clear),
//   in_tdata the key byte and read position. one result per transaction
//   appears on the out_ channel with status, length, cursor and read byte.
//   cfg_ channel writes the eight key code registers at any time; it is
//   always ready.
//   the block handles one transaction at a time. simple keys go from
//   acceptance through the S_OUT state, and the block is ready again in
//   the same cycle as their result appears; insert, delete, history load
//   and history push walk the line through the line ram, with a read
//   state and a write state per byte, and a newline whose length matches
//   the newest entry first compares the two and pushes only if they differ.
//   history is a ring of slots in one ram, so pushing never moves entries.
//   reset clears lengths, cursor and history count and sets the key codes
//   to their defaults at once; ram contents need no clearing pass.
//   a stalled receiver holds the result in the output register; the next
//   transaction is accepted and worked on, and waits before its result.
module line_editor_with_history (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // key_code[7:0], read_pos[14:8], zero[15]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // handled[0], line_entered[1], line_length[8:2],
                                  // cursor_pos[15:9], read_byte[23:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import lew_pkg::*;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, cur_r, cur_nxt;
  logic [LEN_W-1:0] la_r, la_nxt, cnt_r, cnt_nxt, ld_len_r, ld_len_nxt;
  logic [HA_W-1:0]  ha_r, ha_nxt;
  logic [HS_W-1:0]  head_r, head_nxt, hpos_r, hpos_nxt, ld_idx_r, ld_idx_nxt;
  logic [HU_W-1:0]  used_r, used_nxt;
  logic [LEN_W-1:0] hlen_r [HIST_DEPTH];
  logic [LEN_W-1:0] hlen_nxt [HIST_DEPTH];
  logic [7:0]       code_r [NUM_CODES];
  logic [7:0]       chr_r, chr_nxt, rbyte_r, rbyte_nxt;
  logic             hand_r, hand_nxt, ent_r, ent_nxt, mism_r, mism_nxt;
  logic             out_valid_r;
  logic [23:0]      out_data_r;

  logic             l_we, h_we;
  logic [LEN_W-1:0] l_waddr, l_raddr;
  logic [7:0]       l_wdata, l_rdata, h_wdata, h_rdata;

  logic [7:0]       key;
  logic [6:0]       rpos;
  logic [HS_W-1:0]  new_slot;
  logic [HA_W-1:0]  new_base;
  logic [HS_W:0]    psum;
  logic [HS_W-1:0]  ld_phys;
  logic [HS_W-1:0]  tgt_idx;

  assign key       = in_tdata[7:0];
  assign rpos      = in_tdata[14:8];
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign new_slot = (head_r == '0) ? HS_W'(HIST_DEPTH - 1) : head_r - 1'b1;
  assign new_base = HA_W'(new_slot) * HA_W'(MAX_LINE);

  lew_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_line_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  lew_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH * MAX_LINE)) u_hist_ram (
    .clk(clk), .we(h_we), .waddr(ha_r), .wdata(h_wdata),
    .raddr(ha_r), .rdata(h_rdata)
  );

  always_comb begin
    tgt_idx = hpos_r;
    if (in_tuser == CMD_KEY && key != KEY_NL && key == code_r[REG_UP]) begin
      tgt_idx = hpos_r + 1'b1;
    end else begin
      tgt_idx = hpos_r - 1'b1;
    end
    psum = {1'b0, head_r} + {1'b0, tgt_idx};
    if (CW'(psum) >= CW'(HIST_DEPTH)) begin
      psum = psum - (HS_W + 1)'(HIST_DEPTH);
    end
    ld_phys = psum[HS_W-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    len_nxt    = len_r;
    cur_nxt    = cur_r;
    la_nxt     = la_r;
    ha_nxt     = ha_r;
    cnt_nxt    = cnt_r;
    ld_len_nxt = ld_len_r;
    ld_idx_nxt = ld_idx_r;
    head_nxt   = head_r;
    hpos_nxt   = hpos_r;
    used_nxt   = used_r;
    hlen_nxt   = hlen_r;
    chr_nxt    = chr_r;
    rbyte_nxt  = rbyte_r;
    hand_nxt   = hand_r;
    ent_nxt    = ent_r;
    mism_nxt   = mism_r;
    l_we       = 1'b0;
    l_waddr    = la_r;
    l_wdata    = l_rdata;
    l_raddr    = la_r;
    h_we       = 1'b0;
    h_wdata    = l_rdata;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          hand_nxt  = 1'b0;
          ent_nxt   = 1'b0;
          rbyte_nxt = '0;
          mism_nxt  = 1'b0;
          op_nxt    = OP_NONE;
          state_nxt = S_OUT;
          case (in_tuser)
            CMD_KEY: begin
              hand_nxt = 1'b1;
              if (key == KEY_NL) begin
                ent_nxt = 1'b1;
                if (len_r != '0) begin
                  la_nxt  = '0;
                  cnt_nxt = len_r;
                  state_nxt = S_RD;
                  if (used_r != '0 && hlen_r[head_r] == len_r) begin
                    op_nxt = OP_CMP;
                    ha_nxt = HA_W'(head_r) * HA_W'(MAX_LINE);
                  end else begin
                    op_nxt = OP_PUSH;
                    ha_nxt = new_base;
                  end
                end
              end else if (key == code_r[REG_UP]) begin
                if (used_r != '0 && CW'(hpos_r) + 1 < CW'(used_r)) begin
                  op_nxt     = OP_LOAD;
                  ld_idx_nxt = tgt_idx;
                  ld_len_nxt = hlen_r[ld_phys];
                  cnt_nxt    = hlen_r[ld_phys];
                  la_nxt     = '0;
                  ha_nxt     = HA_W'(ld_phys) * HA_W'(MAX_LINE);
                  state_nxt  = (hlen_r[ld_phys] == '0) ? S_FIN : S_RD;
                end
              end else if (key == code_r[REG_DOWN]) begin
                if (used_r != '0) begin
                  if (hpos_r == '0) begin
                    len_nxt = '0;
                    cur_nxt = '0;
                  end else begin
                    op_nxt     = OP_LOAD;
                    ld_idx_nxt = tgt_idx;
                    ld_len_nxt = hlen_r[ld_phys];
                    cnt_nxt    = hlen_r[ld_phys];
                    la_nxt     = '0;
                    ha_nxt     = HA_W'(ld_phys) * HA_W'(MAX_LINE);
                    state_nxt  = (hlen_r[ld_phys] == '0) ? S_FIN : S_RD;
                  end
                end
              end else if (key == code_r[REG_LEFT]) begin
                if (cur_r != '0) cur_nxt = cur_r - 1'b1;
              end else if (key == code_r[REG_RIGHT]) begin
                if (cur_r < len_r) cur_nxt = cur_r + 1'b1;
              end else if (key == code_r[REG_HOME]) begin
                cur_nxt = '0;
              end else if (key == code_r[REG_END]) begin
                cur_nxt = len_r;
              end else if (key == code_r[REG_DELETE]) begin
                if (cur_r < len_r) begin
                  op_nxt    = OP_DEL;
                  la_nxt    = cur_r + 1'b1;
                  cnt_nxt   = len_r - cur_r - 1'b1;
                  state_nxt = (len_r - cur_r == 1) ? S_FIN : S_RD;
                end
              end else if (key == KEY_BS) begin
                if (cur_r != '0) begin
                  cur_nxt   = cur_r - 1'b1;
                  op_nxt    = OP_DEL;
                  la_nxt    = cur_r;
                  cnt_nxt   = len_r - cur_r;
                  state_nxt = (len_r == cur_r) ? S_FIN : S_RD;
                end
              end else if (key == KEY_TAB || key == code_r[REG_BACK_TAB]) begin
                op_nxt = OP_NONE;
              end else if (key >= PRINT_LO && key <= PRINT_HI) begin
                if (CW'(len_r) + 1 < CW'(MAX_LINE)) begin
                  op_nxt    = OP_INS;
                  chr_nxt   = key;
                  la_nxt    = len_r - 1'b1;
                  cnt_nxt   = len_r - cur_r;
                  state_nxt = (len_r == cur_r) ? S_FIN : S_RD;
                end
              end else begin
                hand_nxt = 1'b0;
              end
            end
            CMD_READ: begin
              if (CW'(rpos) < CW'(len_r)) begin
                op_nxt    = OP_READ;
                la_nxt    = LEN_W'(rpos);
                cnt_nxt   = LEN_W'(1);
                state_nxt = S_RD;
              end
            end
            CMD_CLEAR: begin
              len_nxt = '0;
              cur_nxt = '0;
            end
            default: begin
              op_nxt = OP_NONE;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = (cnt_r == LEN_W'(1)) ? S_FIN : S_RD;
        case (op_r)
          OP_INS: begin
            l_we    = 1'b1;
            l_waddr = la_r + 1'b1;
            la_nxt  = la_r - 1'b1;
          end
          OP_DEL: begin
            l_we    = 1'b1;
            l_waddr = la_r - 1'b1;
            la_nxt  = la_r + 1'b1;
          end
          OP_PUSH: begin
            h_we   = 1'b1;
            la_nxt = la_r + 1'b1;
            ha_nxt = ha_r + 1'b1;
          end
          OP_LOAD: begin
            l_we    = 1'b1;
            l_wdata = h_rdata;
            la_nxt  = la_r + 1'b1;
            ha_nxt  = ha_r + 1'b1;
          end
          OP_CMP: begin
            if (l_rdata != h_rdata) mism_nxt = 1'b1;
            la_nxt = la_r + 1'b1;
            ha_nxt = ha_r + 1'b1;
          end
          OP_READ: begin
            rbyte_nxt = l_rdata;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_FIN: begin
        state_nxt = S_OUT;
        case (op_r)
          OP_INS: begin
            l_we    = 1'b1;
            l_waddr = cur_r;
            l_wdata = chr_r;
            cur_nxt = cur_r + 1'b1;
            len_nxt = len_r + 1'b1;
          end
          OP_DEL: begin
            len_nxt = len_r - 1'b1;
          end
          OP_PUSH: begin
            hlen_nxt[new_slot] = len_r;
            head_nxt = new_slot;
            if (CW'(used_r) < CW'(HIST_DEPTH)) used_nxt = used_r + 1'b1;
            hpos_nxt = '0;
          end
          OP_LOAD: begin
            len_nxt  = ld_len_r;
            cur_nxt  = ld_len_r;
            hpos_nxt = ld_idx_r;
          end
          OP_CMP: begin
            if (mism_r) begin
              op_nxt    = OP_PUSH;
              la_nxt    = '0;
              ha_nxt    = new_base;
              cnt_nxt   = len_r;
              state_nxt = S_RD;
            end
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_NONE;
      len_r       <= '0;
      cur_r       <= '0;
      head_r      <= '0;
      hpos_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) hlen_r[i] <= '0;
      code_r[REG_UP]       <= 8'd128;
      code_r[REG_DOWN]     <= 8'd129;
      code_r[REG_LEFT]     <= 8'd130;
      code_r[REG_RIGHT]    <= 8'd131;
      code_r[REG_HOME]     <= 8'd132;
      code_r[REG_END]      <= 8'd133;
      code_r[REG_DELETE]   <= 8'd134;
      code_r[REG_BACK_TAB] <= 8'd135;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      len_r   <= len_nxt;
      cur_r   <= cur_nxt;
      head_r  <= head_nxt;
      hpos_r  <= hpos_nxt;
      used_r  <= used_nxt;
      hlen_r  <= hlen_nxt;
      if (cfg_valid) code_r[cfg_index] <= cfg_data;
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    la_r     <= la_nxt;
    ha_r     <= ha_nxt;
    cnt_r    <= cnt_nxt;
    ld_len_r <= ld_len_nxt;
    ld_idx_r <= ld_idx_nxt;
    chr_r    <= chr_nxt;
    rbyte_r  <= rbyte_nxt;
    hand_r   <= hand_nxt;
    ent_r    <= ent_nxt;
    mism_r   <= mism_nxt;
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= {rbyte_r, 7'(cur_r), 7'(len_r), ent_r, hand_r};
    end
  end

endmodule

// File: sv/lew_ram.sv
// generic simple dual port ram with registered read
module lew_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
